### sv/cmds_pkg.sv
// shared types and codes of the chroma mcu downsampler
package cmds_pkg;

	// operation picked from the input and output block counts
	typedef enum logic [1:0] {
		MODE_COPY  = 2'd0,
		MODE_H2    = 2'd1,
		MODE_HV2   = 2'd2,
		MODE_UNSUP = 2'd3
	} mode_t;

	// configuration register indexes
	localparam logic [1:0] CFG_IN_H  = 2'd0;
	localparam logic [1:0] CFG_IN_V  = 2'd1;
	localparam logic [1:0] CFG_OUT_H = 2'd2;
	localparam logic [1:0] CFG_OUT_V = 2'd3;

	// eight 8-bit samples, lane 0 is the leftmost
	typedef logic [7:0][7:0] pix_row_t;

	// one read step issued by the controller
	typedef struct packed {
		logic        valid;
		logic        unsup;
		logic        last_word;
		logic        final_row;
		mode_t       mode;
		logic [1:0]  word;
		logic [1:0]  blk_x;
		logic [1:0]  blk_y;
		logic [2:0]  row;
		logic [1:0]  in_h;
		logic [1:0]  block_number;
	} rd_cmd_t;

endpackage

### sv/chroma_mcu_downsampler.sv
// top level of the chroma mcu downsampler: ports, controller and datapath
// the load transaction that completes the plane sets busy, and the
//   first result then passes through the store read register and the result register
// results then come at one row per cycle (reorder), or one row per two or four store reads
//   (4:2:2, 4:2:0), set by the single read port of the segment store (one 64-bit word a cycle)
// busy drops in the cycle that carries the last result; the receiver cannot stall
// reset (arst_n low) clears the load counter and the sequencer and loads the block counts
//   2, 2, 1, 1; the segment store is not cleared
module chroma_mcu_downsampler #(
	parameter int MAX_BLOCKS_H = 2,
	parameter int MAX_BLOCKS_V = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	// input transactions
	input  logic       start,
	output logic       busy,
	input  logic [7:0] pixel_0,
	input  logic [7:0] pixel_1,
	input  logic [7:0] pixel_2,
	input  logic [7:0] pixel_3,
	input  logic [7:0] pixel_4,
	input  logic [7:0] pixel_5,
	input  logic [7:0] pixel_6,
	input  logic [7:0] pixel_7,
	// configuration writes
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [1:0] cfg_data,
	// result transactions
	output logic       result_strobe,
	output logic [7:0] out_pixel_0,
	output logic [7:0] out_pixel_1,
	output logic [7:0] out_pixel_2,
	output logic [7:0] out_pixel_3,
	output logic [7:0] out_pixel_4,
	output logic [7:0] out_pixel_5,
	output logic [7:0] out_pixel_6,
	output logic [7:0] out_pixel_7,
	output logic [1:0] block_number,
	output logic [2:0] row_in_block,
	output logic       final_row,
	output logic       unsupported
);
	import cmds_pkg::*;

	// one store word per 8-sample row segment
	localparam int SEG_DEPTH = MAX_BLOCKS_H * MAX_BLOCKS_V * 8;
	localparam int SEG_W     = $clog2(SEG_DEPTH);

	logic             wr_en;
	logic [SEG_W-1:0] wr_addr;
	pix_row_t         wr_data;
	rd_cmd_t          cmd;
	pix_row_t         out_row;

	// lane 0 holds the leftmost raster sample
	assign wr_data[0] = pixel_0;
	assign wr_data[1] = pixel_1;
	assign wr_data[2] = pixel_2;
	assign wr_data[3] = pixel_3;
	assign wr_data[4] = pixel_4;
	assign wr_data[5] = pixel_5;
	assign wr_data[6] = pixel_6;
	assign wr_data[7] = pixel_7;

	// controller: counts segments in, then walks the output blocks row by row,
	// issuing one store read per cycle (1, 2 or 4 reads per output row)
	cmds_ctrl #(
		.MAX_BLOCKS_H (MAX_BLOCKS_H),
		.MAX_BLOCKS_V (MAX_BLOCKS_V)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.cmd       (cmd)
	);

	// datapath: store, pair averages, row assembly and the result register
	cmds_datapath #(
		.SEG_DEPTH (SEG_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.cmd           (cmd),
		.out_row       (out_row),
		.block_number  (block_number),
		.row_in_block  (row_in_block),
		.final_row     (final_row),
		.unsupported   (unsupported),
		.result_strobe (result_strobe)
	);

	assign out_pixel_0 = out_row[0];
	assign out_pixel_1 = out_row[1];
	assign out_pixel_2 = out_row[2];
	assign out_pixel_3 = out_row[3];
	assign out_pixel_4 = out_row[4];
	assign out_pixel_5 = out_row[5];
	assign out_pixel_6 = out_row[6];
	assign out_pixel_7 = out_row[7];

endmodule

### sv/cmds_ctrl.sv
// controller: configuration registers, load counter and emit sequencer
module cmds_ctrl #(
	parameter int MAX_BLOCKS_H = 2,
	parameter int MAX_BLOCKS_V = 2,
	localparam int SEG_DEPTH = MAX_BLOCKS_H * MAX_BLOCKS_V * 8,
	localparam int SEG_W = $clog2(SEG_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [1:0]         cfg_data,
	output logic               wr_en,
	output logic [SEG_W-1:0]   wr_addr,
	output cmds_pkg::rd_cmd_t  cmd
);
	import cmds_pkg::*;

	localparam int CNT_W = $clog2(SEG_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_EMIT  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t           state_q;
	logic [1:0]       in_h_q, in_v_q, out_h_q, out_v_q;
	logic [SEG_W-1:0] seg_q;
	mode_t            mode_q;
	logic [1:0]       w_q;
	logic [2:0]       i_q;
	logic [1:0]       bx_q, by_q;

	logic [2:0]       bh_c, bv_c;
	logic [5:0]       blk_prod_c;
	logic [CNT_W-1:0] total_c, seg_inc_c;
	logic             in_ok_c;
	mode_t            mode_c;
	logic [1:0]       w_last_c;
	logic             word_end_c, row_end_c, bx_end_c, by_end_c, plane_end_c;

	// load length uses the clamped counts
	always_comb begin
		if (in_h_q == 2'd0) begin
			bh_c = 3'd1;
		end else if (int'(in_h_q) > MAX_BLOCKS_H) begin
			bh_c = 3'(MAX_BLOCKS_H);
		end else begin
			bh_c = 3'(in_h_q);
		end
		if (in_v_q == 2'd0) begin
			bv_c = 3'd1;
		end else if (int'(in_v_q) > MAX_BLOCKS_V) begin
			bv_c = 3'(MAX_BLOCKS_V);
		end else begin
			bv_c = 3'(in_v_q);
		end
	end

	assign blk_prod_c = {3'b000, bh_c} * {3'b000, bv_c};
	assign total_c    = CNT_W'({blk_prod_c, 3'b000});
	assign seg_inc_c  = CNT_W'(seg_q) + CNT_W'(1);

	// mode decode on the raw register values
	always_comb begin
		in_ok_c = (in_h_q != 2'd0) && (int'(in_h_q) <= MAX_BLOCKS_H) &&
			(in_v_q != 2'd0) && (int'(in_v_q) <= MAX_BLOCKS_V);
		mode_c = MODE_UNSUP;
		if (in_ok_c) begin
			if (in_h_q == out_h_q && in_v_q == out_v_q) begin
				mode_c = MODE_COPY;
			end else if ({1'b0, in_h_q} == {out_h_q, 1'b0} && in_v_q == out_v_q) begin
				mode_c = MODE_H2;
			end else if ({1'b0, in_h_q} == {out_h_q, 1'b0} &&
					{1'b0, in_v_q} == {out_v_q, 1'b0}) begin
				mode_c = MODE_HV2;
			end
		end
	end

	always_comb begin
		case (mode_q)
			MODE_COPY: w_last_c = 2'd0;
			MODE_H2:   w_last_c = 2'd1;
			MODE_HV2:  w_last_c = 2'd3;
			default:   w_last_c = 2'd0;
		endcase
	end

	assign word_end_c  = (w_q == w_last_c);
	assign row_end_c   = (i_q == 3'd7);
	assign bx_end_c    = (bx_q == 2'(out_h_q - 2'd1));
	assign by_end_c    = (by_q == 2'(out_v_q - 2'd1));
	assign plane_end_c = (mode_q == MODE_UNSUP) ||
		(word_end_c && row_end_c && bx_end_c && by_end_c);

	assign busy    = (state_q != ST_LOAD);
	assign wr_en   = start && (state_q == ST_LOAD);
	assign wr_addr = seg_q;

	always_comb begin
		cmd              = '0;
		cmd.valid        = (state_q == ST_EMIT);
		cmd.unsup        = (mode_q == MODE_UNSUP);
		cmd.last_word    = word_end_c || (mode_q == MODE_UNSUP);
		cmd.final_row    = plane_end_c;
		cmd.mode         = mode_q;
		cmd.word         = w_q;
		cmd.blk_x        = bx_q;
		cmd.blk_y        = by_q;
		cmd.row          = i_q;
		cmd.in_h         = in_h_q;
		cmd.block_number = 2'(by_q * out_h_q + bx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_h_q  <= 2'd2;
			in_v_q  <= 2'd2;
			out_h_q <= 2'd1;
			out_v_q <= 2'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IN_H:  in_h_q  <= cfg_data;
				CFG_IN_V:  in_v_q  <= cfg_data;
				CFG_OUT_H: out_h_q <= cfg_data;
				CFG_OUT_V: out_v_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			seg_q   <= '0;
			mode_q  <= MODE_COPY;
			w_q     <= '0;
			i_q     <= '0;
			bx_q    <= '0;
			by_q    <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (start) begin
						if (seg_inc_c >= total_c) begin
							seg_q   <= '0;
							mode_q  <= mode_c;
							state_q <= ST_EMIT;
						end else begin
							seg_q <= SEG_W'(seg_inc_c);
						end
					end
				end
				ST_EMIT: begin
					if (plane_end_c) begin
						w_q     <= '0;
						i_q     <= '0;
						bx_q    <= '0;
						by_q    <= '0;
						state_q <= ST_DRAIN;
					end else if (!word_end_c) begin
						w_q <= w_q + 2'd1;
					end else begin
						w_q <= '0;
						if (!row_end_c) begin
							i_q <= i_q + 3'd1;
						end else begin
							i_q <= '0;
							if (!bx_end_c) begin
								bx_q <= bx_q + 2'd1;
							end else begin
								bx_q <= '0;
								by_q <= by_q + 2'd1;
							end
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_LOAD;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	a_read_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid |-> busy) else $error("read step issued while not busy");
	a_drain_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |=> state_q == ST_LOAD) else $error("drain longer than a cycle");
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.final_row |-> cmd.last_word) else $error("final row not on last word");
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> int'(seg_q) < SEG_DEPTH) else $error("segment counter out of range");

endmodule

### sv/cmds_datapath.sv
// datapath: segment store, pair averaging and result registers
module cmds_datapath #(
	parameter int SEG_DEPTH = 32,
	localparam int SEG_W = $clog2(SEG_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [SEG_W-1:0]   wr_addr,
	input  cmds_pkg::pix_row_t wr_data,
	input  cmds_pkg::rd_cmd_t  cmd,
	output cmds_pkg::pix_row_t out_row,
	output logic [1:0]         block_number,
	output logic [2:0]         row_in_block,
	output logic               final_row,
	output logic               unsupported,
	output logic               result_strobe
);
	import cmds_pkg::*;

	pix_row_t mem [SEG_DEPTH];

	logic [5:0]       rast_row_c;
	logic [2:0]       word_col_c;
	logic [8:0]       addr_full_c;
	logic [SEG_W-1:0] rd_addr_c;

	pix_row_t   rdata_s1;
	rd_cmd_t    cmd_s1;
	logic       vld_s1;

	pix_row_t   acc_q, top_q, acc_d, top_d;
	logic [3:0][7:0] pair_avg_c;

	pix_row_t   out_q;
	logic [1:0] bn_q;
	logic [2:0] row_q;
	logic       final_q, unsup_q, strobe_q;

	// raster row and word column of this read step
	always_comb begin
		if (cmd.mode == MODE_HV2) begin
			rast_row_c = 6'({cmd.blk_y, 4'b0000}) + 6'({cmd.row, 1'b0}) + 6'(cmd.word[1]);
		end else begin
			rast_row_c = 6'({cmd.blk_y, 3'b000}) + 6'(cmd.row);
		end
		if (cmd.mode == MODE_COPY) begin
			word_col_c = 3'(cmd.blk_x);
		end else begin
			word_col_c = 3'({cmd.blk_x, 1'b0}) + 3'(cmd.word[0]);
		end
	end

	assign addr_full_c = 9'(rast_row_c) * 9'(cmd.in_h) + 9'(word_col_c);
	assign rd_addr_c   = addr_full_c[SEG_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.valid && !cmd.unsup) begin
			rdata_s1 <= mem[rd_addr_c];
		end
		cmd_s1 <= cmd;
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			pair_avg_c[k] = 8'(({1'b0, rdata_s1[2*k]} + {1'b0, rdata_s1[2*k+1]}) >> 1);
		end
	end

	// fold the returned word into the row being built
	always_comb begin
		logic [2:0] lane;
		lane  = 3'd0;
		acc_d = acc_q;
		top_d = top_q;
		case (cmd_s1.mode)
			MODE_COPY: begin
				acc_d = rdata_s1;
			end
			MODE_H2: begin
				for (int k = 0; k < 4; k++) begin
					lane = {cmd_s1.word[0], 2'(k)};
					acc_d[lane] = pair_avg_c[k];
				end
			end
			MODE_HV2: begin
				for (int k = 0; k < 4; k++) begin
					lane = {cmd_s1.word[0], 2'(k)};
					if (!cmd_s1.word[1]) begin
						top_d[lane] = pair_avg_c[k];
					end else begin
						acc_d[lane] = 8'(({1'b0, top_q[lane]} + {1'b0, pair_avg_c[k]}) >> 1);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= acc_d;
			top_q <= top_d;
		end
		if (vld_s1 && cmd_s1.last_word) begin
			out_q   <= cmd_s1.unsup ? '0 : acc_d;
			bn_q    <= cmd_s1.unsup ? 2'd0 : cmd_s1.block_number;
			row_q   <= cmd_s1.unsup ? 3'd0 : cmd_s1.row;
			final_q <= cmd_s1.final_row;
			unsup_q <= cmd_s1.unsup;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			vld_s1   <= cmd.valid;
			strobe_q <= vld_s1 && cmd_s1.last_word;
		end
	end

	assign out_row       = out_q;
	assign block_number  = bn_q;
	assign row_in_block  = row_q;
	assign final_row     = final_q;
	assign unsupported   = unsup_q;
	assign result_strobe = strobe_q;

	a_unsup_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && unsupported |-> final_row && block_number == 2'd0 &&
		row_in_block == 3'd0 && out_row == '0) else $error("bad unsupported result");
	a_final_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && cmd_s1.final_row |=> result_strobe && final_row)
		else $error("final row not delivered");
	a_top_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && cmd_s1.mode == MODE_HV2 && !cmd_s1.word[1] |=> !result_strobe)
		else $error("result from a top-row word");

endmodule
